// ===== rtl/core/pfma_pkg.sv =====
package pfma_pkg;

    localparam int TICK_W     = 27;
    localparam int DATA_W     = 16;
    localparam int LIMIT_W    = 8;
    localparam int OVF_W      = 8;
    localparam int TOTAL_W    = 24;
    localparam int SCALE_W    = 10;
    localparam int DIVIDEND_W = 37;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam int DEF_AVG_DEPTH = 8;
    localparam int DIV_STEPS     = DIVIDEND_W;
    localparam int DIV_CNT_W     = 6;

    localparam logic [SCALE_W-1:0] MILLI_SCALE = 10'd1000;

    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_TICK_RATE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CORRECTION = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MEAS_MIN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MEAS_MAX   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REJ_LIMIT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ALARM_LOW  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ALARM_HIGH = 3'd7;

    localparam logic [TICK_W-1:0]  RST_TICK_RATE  = 27'd1000000;
    localparam logic [DATA_W-1:0]  RST_PERIOD     = 16'hFFFF;
    localparam logic [DATA_W-1:0]  RST_CORRECTION = 16'h0000;
    localparam logic [DATA_W-1:0]  RST_MEAS_MIN   = 16'h0000;
    localparam logic [DATA_W-1:0]  RST_MEAS_MAX   = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] RST_REJ_LIMIT  = 8'd3;
    localparam logic [DATA_W-1:0]  RST_ALARM_LOW  = 16'h0000;
    localparam logic [DATA_W-1:0]  RST_ALARM_HIGH = 16'hFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_ALARM = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_rate_hz;
        logic [DATA_W-1:0]  timer_period;
        logic [DATA_W-1:0]  correction;
        logic [DATA_W-1:0]  meas_min;
        logic [DATA_W-1:0]  meas_max;
        logic [LIMIT_W-1:0] reject_limit;
        logic [DATA_W-1:0]  alarm_low;
        logic [DATA_W-1:0]  alarm_high;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_step;
        logic check;
        logic push;
        logic stat;
        logic timeout;
        logic load_out;
    } t_dp_cmd;

endpackage

// ===== rtl/core/pfma_ctrl.sv =====
module pfma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cmd,
    input  logic              i_out_stall,
    input  logic              i_reject,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output pfma_pkg::t_dp_cmd o_ctl
);
    import pfma_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_CHECK,
        S_PUSH,
        S_STAT,
        S_TOUT,
        S_FIN
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIV_CNT_W-1:0]  n_cnt;
    logic                  r_out_valid;
    logic                  n_out_valid;

    always_comb begin
        o_ctl       = '0;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state = (i_cmd == CMD_TIMEOUT) ? S_TOUT : S_MUL;
                end
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_ctl.check = 1'b1;
                n_state     = i_reject ? S_IDLE : S_PUSH;
            end
            S_PUSH: begin
                o_ctl.push = 1'b1;
                n_state    = S_STAT;
            end
            S_STAT: begin
                o_ctl.stat = 1'b1;
                n_state    = S_FIN;
            end
            S_TOUT: begin
                o_ctl.timeout = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctl.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_out |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a stalled transfer");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MUL || r_state == S_TOUT))
        else $error("accepted transfer did not start work");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divider step count overran");

endmodule

// ===== rtl/core/pfma_datapath.sv =====
module pfma_datapath #(
    parameter int AVG_DEPTH = pfma_pkg::DEF_AVG_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfma_pkg::t_cfg                i_cfg,
    input  pfma_pkg::t_dp_cmd             i_ctl,
    input  logic [pfma_pkg::OVF_W-1:0]    i_overflow_count,
    input  logic [pfma_pkg::DATA_W-1:0]   i_capture_value,
    output logic                          o_reject,
    output logic [pfma_pkg::DATA_W-1:0]   o_average,
    output logic                          o_average_valid,
    output logic [pfma_pkg::STATUS_W-1:0] o_status,
    output logic                          o_status_changed
);
    import pfma_pkg::*;

    localparam int AW = $clog2(AVG_DEPTH);
    localparam int SW = DATA_W + AW;
    localparam logic [AW-1:0] SLOT_LAST = AW'(AVG_DEPTH - 1);

    logic [OVF_W-1:0]      r_ovf;
    logic [DATA_W-1:0]     r_cap;
    logic [TOTAL_W-1:0]    r_total;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [TOTAL_W-1:0]    r_rem;
    logic [DATA_W-1:0]     r_m;
    logic [DATA_W-1:0]     r_mem [AVG_DEPTH];
    logic [DATA_W-1:0]     r_rd_data;
    logic                  r_old_vld;
    logic [AVG_DEPTH-1:0]  r_fill;
    logic [AW-1:0]         r_slot;
    logic [SW-1:0]         r_sum;
    logic [LIMIT_W-1:0]    r_rej_cnt;
    t_status               r_status;
    logic [DATA_W-1:0]     r_res_avg;
    logic                  r_res_vld;
    t_status               r_res_status;
    logic                  r_res_chg;
    logic [DATA_W-1:0]     r_out_avg;
    logic                  r_out_vld;
    t_status               r_out_status;
    logic                  r_out_chg;

    logic [TOTAL_W:0]      rem_sh;
    logic [TOTAL_W:0]      rem_diff;
    logic                  rem_ge;
    logic [DATA_W-1:0]     q_sat;
    logic [DATA_W-1:0]     m_val;
    logic                  m_out;
    logic                  under_limit;
    logic [DATA_W-1:0]     old_val;
    logic [DATA_W-1:0]     avg;
    t_status               n_status;

    always_comb begin
        rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
        rem_diff = rem_sh - {1'b0, r_total};
        rem_ge   = (rem_sh >= {1'b0, r_total});
        if ((r_total == '0) || (|r_quo[DIVIDEND_W-1:DATA_W])) begin
            q_sat = '1;
        end else begin
            q_sat = r_quo[DATA_W-1:0];
        end
        m_val       = q_sat + i_cfg.correction;
        m_out       = (m_val > i_cfg.meas_max) || (m_val < i_cfg.meas_min);
        under_limit = (r_rej_cnt < i_cfg.reject_limit);
        old_val     = r_old_vld ? r_rd_data : '0;
        avg         = r_sum[SW-1:AW];
        n_status    = ((avg > i_cfg.alarm_low) && (avg < i_cfg.alarm_high)) ? ST_OK : ST_ALARM;
    end

    assign o_reject = m_out && under_limit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_ovf <= i_overflow_count;
            r_cap <= i_capture_value;
        end
        if (i_ctl.mul) begin
            r_total <= TOTAL_W'(TOTAL_W'(r_ovf) * TOTAL_W'(i_cfg.timer_period))
                       + TOTAL_W'(r_cap);
            r_quo   <= DIVIDEND_W'(i_cfg.tick_rate_hz) * DIVIDEND_W'(MILLI_SCALE);
            r_rem   <= '0;
        end
        if (i_ctl.div_step) begin
            r_rem <= rem_ge ? rem_diff[TOTAL_W-1:0] : rem_sh[TOTAL_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], rem_ge};
        end
        if (i_ctl.check) begin
            r_m       <= m_val;
            r_rd_data <= r_mem[r_slot];
            r_old_vld <= r_fill[r_slot];
        end
        if (i_ctl.push) begin
            r_mem[r_slot] <= r_m;
        end
        if (i_ctl.stat) begin
            r_res_avg    <= avg;
            r_res_vld    <= 1'b1;
            r_res_status <= n_status;
            r_res_chg    <= (n_status != r_status);
        end
        if (i_ctl.timeout) begin
            r_res_avg    <= '0;
            r_res_vld    <= 1'b0;
            r_res_status <= ST_ERROR;
            r_res_chg    <= (r_status != ST_ERROR);
        end
        if (i_ctl.load_out) begin
            r_out_avg    <= r_res_avg;
            r_out_vld    <= r_res_vld;
            r_out_status <= r_res_status;
            r_out_chg    <= r_res_chg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_slot    <= '0;
            r_sum     <= '0;
            r_rej_cnt <= '0;
            r_status  <= ST_OK;
        end else begin
            if (i_ctl.check) begin
                if (!m_out) begin
                    r_rej_cnt <= '0;
                end else if (under_limit) begin
                    r_rej_cnt <= r_rej_cnt + 1'b1;
                end
            end
            if (i_ctl.push) begin
                r_sum          <= r_sum - SW'(old_val) + SW'(r_m);
                r_fill[r_slot] <= 1'b1;
                r_slot         <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
            end
            if (i_ctl.stat) begin
                r_status <= n_status;
            end
            if (i_ctl.timeout) begin
                r_status <= ST_ERROR;
            end
        end
    end

    assign o_average        = r_out_avg;
    assign o_average_valid  = r_out_vld;
    assign o_status         = r_out_status;
    assign o_status_changed = r_out_chg;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("write slot out of range");

    a_slot_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |=> (r_slot != $past(r_slot)))
        else $error("write slot did not advance");

    a_stat_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.stat |=> (r_status == ST_OK || r_status == ST_ALARM))
        else $error("average update left error status");

endmodule

// ===== rtl/core/period_frequency_meter_averager_core.sv =====
// Reciprocal frequency meter with a moving average. Each capture transfer carries an
// overflow count and a capture value; the block forms total = overflows * timer_period +
// capture, computes floor(tick_rate_hz * 1000 / total) saturated to 65535 (also for a
// zero total), adds the signed correction modulo 65536 and screens the result against
// [meas_min, meas_max]. Out-of-range values are dropped without a result until
// reject_limit consecutive rejects have been seen. Accepted values replace the oldest
// entry of an AVG_DEPTH-deep store (AVG_DEPTH a power of two, store reads as zero after
// reset); the average is the running sum shifted right by log2(AVG_DEPTH) and sets the
// status to OK when strictly inside (alarm_low, alarm_high), else ALARM. A timeout
// transfer sets ERROR and returns a result with average 0 and average_valid 0. One item
// is in work at a time: a capture runs the multiply, the 37-step restoring divider, the
// range check, the store update and the status update before it is loaded into the
// output register and the block is idle again; a timeout goes to its result directly,
// and a dropped capture frees the input after the range check. A finished result waits in
// an output register, so the next transfer is accepted while it is still stalled; a
// second finished result waits while that register stays stalled, and the input stalls
// with it. Registers sit on an APB port at byte address 4*i, with pready always high.
module period_frequency_meter_averager_core #(
    parameter int AVG_DEPTH = pfma_pkg::DEF_AVG_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [pfma_pkg::OVF_W-1:0]      i_overflow_count,
    input  logic [pfma_pkg::DATA_W-1:0]     i_capture_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pfma_pkg::DATA_W-1:0]     o_average,
    output logic                            o_average_valid,
    output logic [pfma_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_status_changed,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfma_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pfma_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pfma_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import pfma_pkg::*;

    t_cfg                  r_cfg;
    t_dp_cmd               ctl;
    logic                  reject;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_rate_hz <= RST_TICK_RATE;
            r_cfg.timer_period <= RST_PERIOD;
            r_cfg.correction   <= RST_CORRECTION;
            r_cfg.meas_min     <= RST_MEAS_MIN;
            r_cfg.meas_max     <= RST_MEAS_MAX;
            r_cfg.reject_limit <= RST_REJ_LIMIT;
            r_cfg.alarm_low    <= RST_ALARM_LOW;
            r_cfg.alarm_high   <= RST_ALARM_HIGH;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TICK_RATE:  r_cfg.tick_rate_hz <= pwdata[TICK_W-1:0];
                REG_PERIOD:     r_cfg.timer_period <= pwdata[DATA_W-1:0];
                REG_CORRECTION: r_cfg.correction   <= pwdata[DATA_W-1:0];
                REG_MEAS_MIN:   r_cfg.meas_min     <= pwdata[DATA_W-1:0];
                REG_MEAS_MAX:   r_cfg.meas_max     <= pwdata[DATA_W-1:0];
                REG_REJ_LIMIT:  r_cfg.reject_limit <= pwdata[LIMIT_W-1:0];
                REG_ALARM_LOW:  r_cfg.alarm_low    <= pwdata[DATA_W-1:0];
                REG_ALARM_HIGH: r_cfg.alarm_high   <= pwdata[DATA_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TICK_RATE:  prdata = CFG_DATA_W'(r_cfg.tick_rate_hz);
            REG_PERIOD:     prdata = CFG_DATA_W'(r_cfg.timer_period);
            REG_CORRECTION: prdata = CFG_DATA_W'(r_cfg.correction);
            REG_MEAS_MIN:   prdata = CFG_DATA_W'(r_cfg.meas_min);
            REG_MEAS_MAX:   prdata = CFG_DATA_W'(r_cfg.meas_max);
            REG_REJ_LIMIT:  prdata = CFG_DATA_W'(r_cfg.reject_limit);
            REG_ALARM_LOW:  prdata = CFG_DATA_W'(r_cfg.alarm_low);
            REG_ALARM_HIGH: prdata = CFG_DATA_W'(r_cfg.alarm_high);
        endcase
    end

    pfma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_stall (i_out_stall),
        .i_reject    (reject),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    pfma_datapath #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_ctl            (ctl),
        .i_overflow_count (i_overflow_count),
        .i_capture_value  (i_capture_value),
        .o_reject         (reject),
        .o_average        (o_average),
        .o_average_valid  (o_average_valid),
        .o_status         (o_status),
        .o_status_changed (o_status_changed)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import pfma_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int STORE_DEPTH   = DEF_AVG_DEPTH;
    localparam int SLOT_W        = $clog2(STORE_DEPTH);
    localparam int SUM_W         = DATA_W + SLOT_W;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int MAX_REPORTS   = 40;
    localparam int WATCHDOG_NS   = 8_000_000;
    localparam int DIR_ROWS      = 31;

    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic              average_valid;
        t_status           status;
        logic              status_changed;
    } t_reading;

    typedef enum logic [1:0] {
        ROW_CAPTURE,
        ROW_TIMEOUT,
        ROW_WRITE
    } t_row_kind;

    // a: overflow count or register index, b: capture value or register value
    typedef struct packed {
        t_row_kind             kind;
        logic [OVF_W-1:0]      a;
        logic [CFG_DATA_W-1:0] b;
        logic                  typed;
        t_reading              reading;
    } t_row;

    localparam t_reading NO_READING = '0;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd            = CMD_CAPTURE;
    logic [OVF_W-1:0]      i_overflow_count = '0;
    logic [DATA_W-1:0]     i_capture_value  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic [DATA_W-1:0]     o_average;
    logic                  o_average_valid;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_status_changed;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr            = '0;
    logic [CFG_DATA_W-1:0] pwdata           = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  row_typed        = 1'b0;
    t_reading              row_reading      = '0;

    t_cfg                  meter_cfg = '{RST_TICK_RATE, RST_PERIOD, RST_CORRECTION,
                                         RST_MEAS_MIN, RST_MEAS_MAX, RST_REJ_LIMIT,
                                         RST_ALARM_LOW, RST_ALARM_HIGH};
    logic [DATA_W-1:0]     avg_store [STORE_DEPTH];
    logic [SUM_W-1:0]      avg_sum     = '0;
    logic [SLOT_W-1:0]     avg_slot    = '0;
    logic [LIMIT_W-1:0]    reject_run  = '0;
    t_status               meter_status = ST_OK;

    t_reading              pending_readings [$];
    int unsigned           mismatch_count = 0;
    bit                    idling_on = 1'b1;
    bit                    hold_req  = 1'b0;

    t_row directed_rows [DIR_ROWS] = '{
        '{ROW_TIMEOUT, 8'h00, 32'h0,     1'b1, '{16'd0,    1'b0, ST_ERROR, 1'b1}},
        '{ROW_TIMEOUT, 8'hFF, 32'hFFFF,  1'b1, '{16'd0,    1'b0, ST_ERROR, 1'b0}},
        '{ROW_CAPTURE, 8'h00, 32'h0,     1'b1, '{16'd8191, 1'b1, ST_OK,    1'b1}},
        '{ROW_CAPTURE, 8'hFF, 32'hFFFF,  1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h00, 32'h1,     1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h01, 32'h0,     1'b0, NO_READING},
        '{ROW_CAPTURE, 8'hAA, 32'h5555,  1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h55, 32'hAAAA,  1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_MEAS_MAX),   32'd1000,     1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h00, 32'h1,     1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h00, 32'h1,     1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h00, 32'h1,     1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h00, 32'h1,     1'b0, NO_READING},
        '{ROW_CAPTURE, 8'hFF, 32'hFFFF,  1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_ALARM_LOW),  32'd40000,    1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_ALARM_HIGH), 32'd100,      1'b0, NO_READING},
        '{ROW_CAPTURE, 8'd20, 32'h0,     1'b0, NO_READING},
        '{ROW_TIMEOUT, 8'h00, 32'h0,     1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_MEAS_MIN),   32'd50000,    1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_REJ_LIMIT),  32'd0,        1'b0, NO_READING},
        '{ROW_CAPTURE, 8'd3,  32'd7,     1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_CORRECTION), 32'h8000,     1'b0, NO_READING},
        '{ROW_CAPTURE, 8'hFF, 32'hFFFF,  1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_TICK_RATE),  32'd0,        1'b0, NO_READING},
        '{ROW_CAPTURE, 8'd9,  32'd1234,  1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h00, 32'h0,     1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_PERIOD),     32'd0,        1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_TICK_RATE),  32'd100,      1'b0, NO_READING},
        '{ROW_CAPTURE, 8'hFF, 32'd40,    1'b0, NO_READING},
        '{ROW_WRITE,   8'(REG_TICK_RATE),  32'd72000000, 1'b0, NO_READING},
        '{ROW_CAPTURE, 8'h00, 32'hFFFF,  1'b0, NO_READING}
    };

    period_frequency_meter_averager_core #(
        .AVG_DEPTH(STORE_DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_overflow_count (i_overflow_count),
        .i_capture_value  (i_capture_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_average        (o_average),
        .o_average_valid  (o_average_valid),
        .o_status         (o_status),
        .o_status_changed (o_status_changed),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            avg_store[i] = '0;
        end
    end

    function automatic bit meter_step(input logic cmd, input logic [OVF_W-1:0] ovf,
                                      input logic [DATA_W-1:0] cap, output t_reading rd);
        logic [63:0]       total;
        logic [63:0]       quot;
        logic [DATA_W-1:0] mom;
        logic [DATA_W-1:0] avg;
        t_status           prev;
        prev = meter_status;
        rd   = '0;
        if (cmd == CMD_TIMEOUT) begin
            meter_status = ST_ERROR;
        end else begin
            total = 64'(ovf) * 64'(meter_cfg.timer_period) + 64'(cap);
            if (total == 0) begin
                quot = 64'hFFFF;
            end else begin
                quot = 64'(meter_cfg.tick_rate_hz) * 64'(MILLI_SCALE) / total;
                if (quot > 64'hFFFF) begin
                    quot = 64'hFFFF;
                end
            end
            mom = quot[DATA_W-1:0] + meter_cfg.correction;
            if (mom > meter_cfg.meas_max || mom < meter_cfg.meas_min) begin
                if (reject_run < meter_cfg.reject_limit) begin
                    reject_run = reject_run + 1'b1;
                    return 1'b0;
                end
            end else begin
                reject_run = '0;
            end
            avg_sum             = avg_sum - SUM_W'(avg_store[avg_slot]) + SUM_W'(mom);
            avg_store[avg_slot] = mom;
            avg_slot            = avg_slot + 1'b1;
            avg                 = DATA_W'(avg_sum >> SLOT_W);
            rd.average          = avg;
            rd.average_valid    = 1'b1;
            meter_status = (avg > meter_cfg.alarm_low && avg < meter_cfg.alarm_high) ?
                           ST_OK : ST_ALARM;
        end
        rd.status         = meter_status;
        rd.status_changed = (meter_status != prev);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_reading rd;
        t_reading want;
        bit       produced;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("result transfer with none pending", 1, 0);
                end else begin
                    want = pending_readings.pop_front();
                    if (o_average !== want.average)
                        report_mismatch("average", o_average, want.average);
                    if (o_average_valid !== want.average_valid)
                        report_mismatch("average_valid", o_average_valid, want.average_valid);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_status_changed !== want.status_changed)
                        report_mismatch("status_changed", o_status_changed,
                                        want.status_changed);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                produced = meter_step(i_cmd, i_overflow_count, i_capture_value, rd);
                if (row_typed) begin
                    pending_readings.push_back(row_reading);
                end else if (produced) begin
                    pending_readings.push_back(rd);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_TICK_RATE:  meter_cfg.tick_rate_hz = pwdata[TICK_W-1:0];
                    REG_PERIOD:     meter_cfg.timer_period = pwdata[DATA_W-1:0];
                    REG_CORRECTION: meter_cfg.correction   = pwdata[DATA_W-1:0];
                    REG_MEAS_MIN:   meter_cfg.meas_min     = pwdata[DATA_W-1:0];
                    REG_MEAS_MAX:   meter_cfg.meas_max     = pwdata[DATA_W-1:0];
                    REG_REJ_LIMIT:  meter_cfg.reject_limit = pwdata[LIMIT_W-1:0];
                    REG_ALARM_LOW:  meter_cfg.alarm_low    = pwdata[DATA_W-1:0];
                    REG_ALARM_HIGH: meter_cfg.alarm_high   = pwdata[DATA_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_capture(input logic cmd, input logic [OVF_W-1:0] ovf,
                                input logic [DATA_W-1:0] cap, input logic typed,
                                input t_reading reading);
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_overflow_count <= ovf;
        i_capture_value  <= cap;
        row_typed        <= typed;
        row_reading      <= reading;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        write_reg(REG_TICK_RATE,  CFG_DATA_W'(c.tick_rate_hz));
        write_reg(REG_PERIOD,     CFG_DATA_W'(c.timer_period));
        write_reg(REG_CORRECTION, CFG_DATA_W'(c.correction));
        write_reg(REG_MEAS_MIN,   CFG_DATA_W'(c.meas_min));
        write_reg(REG_MEAS_MAX,   CFG_DATA_W'(c.meas_max));
        write_reg(REG_REJ_LIMIT,  CFG_DATA_W'(c.reject_limit));
        write_reg(REG_ALARM_LOW,  CFG_DATA_W'(c.alarm_low));
        write_reg(REG_ALARM_HIGH, CFG_DATA_W'(c.alarm_high));
    endtask

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_cfg              cfg_set;
        t_row              row;
        logic              cmd;
        logic [OVF_W-1:0]  ovf;
        logic [DATA_W-1:0] cap;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            case (row.kind)
                ROW_WRITE: begin
                    wait_idle();
                    write_reg(row.a[REG_IDX_W-1:0], row.b);
                end
                ROW_TIMEOUT: send_capture(CMD_TIMEOUT, row.a, row.b[DATA_W-1:0],
                                          row.typed, row.reading);
                default: send_capture(CMD_CAPTURE, row.a, row.b[DATA_W-1:0],
                                      row.typed, row.reading);
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: cfg_set = '{RST_TICK_RATE, RST_PERIOD, RST_CORRECTION, RST_MEAS_MIN,
                               RST_MEAS_MAX, RST_REJ_LIMIT, RST_ALARM_LOW, RST_ALARM_HIGH};
                1: cfg_set = '{27'd72000000, 16'hFFFF, 16'd100, 16'd4000, 16'd40000,
                               8'd255, 16'd5000, 16'd30000};
                2: cfg_set = '{27'd1, 16'd1, 16'h8000, 16'd0, 16'hFFFF, 8'd0,
                               16'hFFFF, 16'd0};
                3: cfg_set = '{27'd0, 16'd0, 16'h7FFF, 16'd40000, 16'd100, 8'd4,
                               16'd100, 16'd200};
                default: begin
                    cfg_set.tick_rate_hz = TICK_W'($urandom_range(1, 72000000));
                    cfg_set.timer_period = DATA_W'($urandom);
                    cfg_set.correction   = DATA_W'($urandom);
                    cfg_set.meas_min     = DATA_W'($urandom_range(0, 20000));
                    cfg_set.meas_max     = DATA_W'($urandom_range(cfg_set.meas_min, 65535));
                    cfg_set.reject_limit = LIMIT_W'($urandom_range(0, 8));
                    cfg_set.alarm_low    = DATA_W'($urandom_range(0, 30000));
                    cfg_set.alarm_high   = DATA_W'($urandom_range(cfg_set.alarm_low, 65535));
                end
            endcase
            wait_idle();
            apply_cfg(cfg_set);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                idling_on = (ph != PHASES - 1) && ((k % 60) < 40);
                if (ph == 1 && k == 40) begin
                    hold_req = 1'b1;
                end
                cmd = ($urandom_range(0, 99) < 8) ? CMD_TIMEOUT : CMD_CAPTURE;
                case ($urandom_range(0, 3))
                    0:       ovf = '0;
                    1:       ovf = OVF_W'($urandom_range(0, 3));
                    default: ovf = OVF_W'($urandom);
                endcase
                cap = ($urandom_range(0, 4) == 0) ? DATA_W'($urandom_range(0, 15)) :
                                                    DATA_W'($urandom);
                send_capture(cmd, ovf, cap, 1'b0, NO_READING);
                if (idling_on && $urandom_range(0, 3) == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge i_clk);
                end
            end
        end

        idling_on = 1'b0;
        wait_idle();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
